### src/seq_pkg.sv
// Shared constants and codes for the stylus event qualifier.
`default_nettype none

package seq_pkg;

  // Fixed point default: 1 << FRAC_BITS means 1.0
  localparam int FRAC_BITS_DEF = 16;

  // Field widths that do not follow the fraction
  localparam int SCR_W   = 14;
  localparam int MIN_W   = 8;
  localparam int MOUSE_W = 16;
  localparam int MOUSE_SCALE = 65535;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DOWN_THR      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UP_THR        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_DOWN_THR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_UP_THR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_W      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_H      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_MOVE      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLICK_MODE    = 3'd7;

  // Reset values of the registers that do not scale with the fraction
  localparam logic [SCR_W-1:0] SCREEN_W_RST = 14'd1920;
  localparam logic [SCR_W-1:0] SCREEN_H_RST = 14'd1080;
  localparam logic [MIN_W-1:0] MIN_MOVE_RST = 8'd2;

  // Event kinds; the spare kind acts like draw but leaves the eraser alone
  localparam logic [1:0] KIND_UP    = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Stroke events; mouse button codes use the same values
  localparam logic [1:0] EV_CONT = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

endpackage

`default_nettype wire

### src/stylus_event_qualifier_unit.sv
// Top level of the stylus event qualifier: pen hysteresis, point and mouse move output.
`default_nettype none

// Usage
//   in_*  : one stylus record per word. tdata = pos_x, pos_y, pen_pressure;
//           tuser = event_kind, ctrl_held; tlast = batch_end.
//   out_* : one result word per record. tdata = point_x, point_y,
//           point_pressure, mouse_x, mouse_y; tuser = point_valid,
//           stroke_event, erase_mode, mouse_valid, mouse_button.
//   cfg_* : APB write/read of the eight registers at byte address 4*index.
// Timing
//   One shared multiplier runs a seven-step sequence per word: two pixel
//   scalings, two squares, the squared threshold and the two mouse scalings.
//   The result is registered at the end of the final step, and in_tready
//   returns the cycle after, so no new word is taken while one is in flight.
// Stall
//   The result sits in the output register until taken; the next word is
//   accepted meanwhile and runs its sequence, holding in its last step
//   until the output register is free.
// Reset
//   rst_n (synchronous, active low) puts the pen up, clears the eraser and
//   the last mouse position, empties the output and loads register defaults.
module stylus_event_qualifier_unit #(
  parameter int FRAC_BITS = seq_pkg::FRAC_BITS_DEF,
  localparam int IW = FRAC_BITS + 2,
  localparam int QW = FRAC_BITS + 1,
  localparam int IN_RAW_W = 2 * IW + QW,
  localparam int IN_DW = ((IN_RAW_W + 7) / 8) * 8,
  localparam int OUT_RAW_W = 3 * QW + 2 * seq_pkg::MOUSE_W,
  localparam int OUT_DW = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [IN_DW-1:0]            in_tdata,  // pos_x, pos_y, pen_pressure, zero pad
  input  wire logic [2:0]                  in_tuser,  // event_kind[1:0], ctrl_held
  input  wire logic                        in_tlast,  // batch_end
  // result channel
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [OUT_DW-1:0]           out_tdata, // point_x, point_y, point_pressure,
                                                      // mouse_x, mouse_y, zero pad
  output      logic [6:0]                  out_tuser, // point_valid, stroke_event[1:0],
                                                      // erase_mode, mouse_valid,
                                                      // mouse_button[1:0]
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [seq_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [seq_pkg::PDATA_W-1:0] cfg_pwdata,
  output      logic [seq_pkg::PDATA_W-1:0] cfg_prdata,
  output      logic                        cfg_pready
);

  localparam int TW = FRAC_BITS + 3;             // signed compare width
  localparam int MW = QW + seq_pkg::SCR_W;       // multiplier operand width
  localparam int PW = 2 * MW;                    // product width
  localparam int MOW = seq_pkg::MOUSE_W;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
  localparam logic [IW-1:0] DOWN_THR_RST = IW'((45 * (1 << FRAC_BITS)) / 100);
  localparam logic [IW-1:0] UP_THR_RST   = IW'(1 << (FRAC_BITS - 2));
  localparam logic [IW-1:0] CTRL_THR_RST = IW'(-(1 << FRAC_BITS));

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DX   = 3'd1;
  localparam logic [2:0] ST_DY   = 3'd2;
  localparam logic [2:0] ST_AA   = 3'd3;
  localparam logic [2:0] ST_BB   = 3'd4;
  localparam logic [2:0] ST_TT   = 3'd5;
  localparam logic [2:0] ST_MX   = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // ---------------------------------------------------------------- config
  logic [IW-1:0]              down_thr_r, up_thr_r, cdown_thr_r, cup_thr_r;
  logic [seq_pkg::SCR_W-1:0]  scr_w_r, scr_h_r;
  logic [seq_pkg::MIN_W-1:0]  min_move_r;
  logic                       click_r;
  logic                       cfg_wr;
  logic [seq_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[seq_pkg::PADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_thr_r  <= DOWN_THR_RST;
      up_thr_r    <= UP_THR_RST;
      cdown_thr_r <= CTRL_THR_RST;
      cup_thr_r   <= CTRL_THR_RST;
      scr_w_r     <= seq_pkg::SCREEN_W_RST;
      scr_h_r     <= seq_pkg::SCREEN_H_RST;
      min_move_r  <= seq_pkg::MIN_MOVE_RST;
      click_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        seq_pkg::REG_DOWN_THR:      down_thr_r  <= cfg_pwdata[IW-1:0];
        seq_pkg::REG_UP_THR:        up_thr_r    <= cfg_pwdata[IW-1:0];
        seq_pkg::REG_CTRL_DOWN_THR: cdown_thr_r <= cfg_pwdata[IW-1:0];
        seq_pkg::REG_CTRL_UP_THR:   cup_thr_r   <= cfg_pwdata[IW-1:0];
        seq_pkg::REG_SCREEN_W:      scr_w_r     <= cfg_pwdata[seq_pkg::SCR_W-1:0];
        seq_pkg::REG_SCREEN_H:      scr_h_r     <= cfg_pwdata[seq_pkg::SCR_W-1:0];
        seq_pkg::REG_MIN_MOVE:      min_move_r  <= cfg_pwdata[seq_pkg::MIN_W-1:0];
        seq_pkg::REG_CLICK_MODE:    click_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      seq_pkg::REG_DOWN_THR:      cfg_prdata = seq_pkg::PDATA_W'(down_thr_r);
      seq_pkg::REG_UP_THR:        cfg_prdata = seq_pkg::PDATA_W'(up_thr_r);
      seq_pkg::REG_CTRL_DOWN_THR: cfg_prdata = seq_pkg::PDATA_W'(cdown_thr_r);
      seq_pkg::REG_CTRL_UP_THR:   cfg_prdata = seq_pkg::PDATA_W'(cup_thr_r);
      seq_pkg::REG_SCREEN_W:      cfg_prdata = seq_pkg::PDATA_W'(scr_w_r);
      seq_pkg::REG_SCREEN_H:      cfg_prdata = seq_pkg::PDATA_W'(scr_h_r);
      seq_pkg::REG_MIN_MOVE:      cfg_prdata = seq_pkg::PDATA_W'(min_move_r);
      seq_pkg::REG_CLICK_MODE:    cfg_prdata = seq_pkg::PDATA_W'(click_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input capture
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    kind_r;
  logic [QW-1:0] x_r, y_r, pres_r;
  logic          ctrl_r, last_r;
  logic          in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // clamp a raw signed position into [0, 1.0]
  function automatic logic [QW-1:0] clamp_unit(input logic [IW-1:0] raw);
    logic [QW-1:0] r;
    r = raw[QW-1:0];
    if (raw[IW-1])
      return '0;
    else if (r > ONE_Q)
      return ONE_Q;
    else
      return r;
  endfunction

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= clamp_unit(in_tdata[IW-1:0]);
      y_r    <= clamp_unit(in_tdata[2*IW-1:IW]);
      pres_r <= in_tdata[2*IW+QW-1:2*IW];
      kind_r <= in_tuser[1:0];
      ctrl_r <= in_tuser[2];
      last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  logic [QW-1:0]   lx_r, ly_r;
  logic [QW-1:0]   dxm, dym;
  logic [MW-1:0]   a_r, b_r;
  logic [PW:0]     acc_r;
  logic            far_r;
  logic [MOW-1:0]  mx_r;
  logic [MW-1:0]   mul_a, mul_b;
  logic [PW-1:0]   mul_p;
  logic [MW-1:0]   tmin;

  assign dxm  = (x_r >= lx_r) ? (x_r - lx_r) : (lx_r - x_r);
  assign dym  = (y_r >= ly_r) ? (y_r - ly_r) : (ly_r - y_r);
  assign tmin = MW'({min_move_r, {FRAC_BITS{1'b0}}});

  always_comb begin
    case (state_r)
      ST_DX:   begin mul_a = MW'(dxm); mul_b = MW'(scr_w_r); end
      ST_DY:   begin mul_a = MW'(dym); mul_b = MW'(scr_h_r); end
      ST_AA:   begin mul_a = a_r;      mul_b = a_r;          end
      ST_BB:   begin mul_a = b_r;      mul_b = b_r;          end
      ST_TT:   begin mul_a = tmin;     mul_b = tmin;         end
      ST_MX:   begin mul_a = MW'(x_r); mul_b = MW'(seq_pkg::MOUSE_SCALE); end
      ST_DONE: begin mul_a = MW'(y_r); mul_b = MW'(seq_pkg::MOUSE_SCALE); end
      default: begin mul_a = '0;       mul_b = '0;           end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- hysteresis
  logic          pen_r, eraser_r;
  logic [1:0]    ev_r;
  logic          pen_nxt, eraser_nxt;
  logic [1:0]    ev_nxt;
  logic signed [TW-1:0] pres_s, dn_s, up_s;

  assign pres_s = signed'(TW'(pres_r));
  assign dn_s   = TW'(signed'(ctrl_r ? cdown_thr_r : down_thr_r));
  assign up_s   = TW'(signed'(ctrl_r ? cup_thr_r : up_thr_r));

  always_comb begin
    pen_nxt    = pen_r;
    ev_nxt     = seq_pkg::EV_CONT;
    eraser_nxt = eraser_r;
    if (kind_r == seq_pkg::KIND_UP) begin
      if (pen_r) begin
        pen_nxt = 1'b0;
        ev_nxt  = seq_pkg::EV_UP;
      end
    end else if (pen_r) begin
      if (pres_s < up_s) begin
        pen_nxt = 1'b0;
        ev_nxt  = seq_pkg::EV_UP;
      end
    end else if (pres_s > dn_s) begin
      pen_nxt = 1'b1;
      ev_nxt  = seq_pkg::EV_DOWN;
    end
    // the up and unused kinds leave the eraser as it is
    if (kind_r == seq_pkg::KIND_ERASE)
      eraser_nxt = 1'b1;
    else if (kind_r == seq_pkg::KIND_DRAW)
      eraser_nxt = 1'b0;
  end

  // ---------------------------------------------------------------- sequencer
  logic out_valid_r;
  logic out_free;
  logic finish;
  logic point, move;

  assign out_free = !out_valid_r || out_tready;
  assign finish   = (state_r == ST_DONE) && out_free;
  assign point    = ((ev_r != seq_pkg::EV_CONT) || pen_r) && !click_r;
  assign move     = far_r || last_r || (ev_r != seq_pkg::EV_CONT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DX;
      ST_DX:   state_nxt = ST_DY;
      ST_DY:   state_nxt = ST_AA;
      ST_AA:   state_nxt = ST_BB;
      ST_BB:   state_nxt = ST_TT;
      ST_TT:   state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pen_r    <= 1'b0;
      eraser_r <= 1'b0;
      lx_r     <= '0;
      ly_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DX) begin
        pen_r    <= pen_nxt;
        eraser_r <= eraser_nxt;
      end
      // remember where the last mouse move went
      if (finish && move) begin
        lx_r <= x_r;
        ly_r <= y_r;
      end
    end
  end

  // datapath registers of the sequence
  always_ff @(posedge clk) begin
    case (state_r)
      ST_DX: begin
        a_r  <= mul_p[MW-1:0];
        ev_r <= ev_nxt;
      end
      ST_DY: b_r   <= mul_p[MW-1:0];
      ST_AA: acc_r <= (PW+1)'(mul_p);
      ST_BB: acc_r <= acc_r + (PW+1)'(mul_p);
      ST_TT: far_r <= acc_r > (PW+1)'(mul_p);
      ST_MX: mx_r  <= mul_p[FRAC_BITS+MOW-1:FRAC_BITS];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  logic           o_point_r, o_erase_r, o_mouse_r;
  logic [1:0]     o_stroke_r, o_button_r;
  logic [QW-1:0]  o_px_r, o_py_r, o_pp_r;
  logic [MOW-1:0] o_mx_r, o_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      o_point_r  <= point;
      o_stroke_r <= ev_r;
      o_erase_r  <= eraser_r;
      o_px_r     <= point ? x_r : '0;
      o_py_r     <= point ? y_r : '0;
      o_pp_r     <= point ? pres_r : '0;
      o_mouse_r  <= move;
      o_mx_r     <= move ? mx_r : '0;
      o_my_r     <= move ? mul_p[FRAC_BITS+MOW-1:FRAC_BITS] : '0;
      o_button_r <= (move && click_r) ? ev_r : seq_pkg::EV_CONT;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({o_my_r, o_mx_r, o_pp_r, o_py_r, o_px_r});
  assign out_tuser  = {o_button_r, o_mouse_r, o_erase_r, o_stroke_r, o_point_r};

  // ---------------------------------------------------------------- checks
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result appeared outside the final step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DX)
    else $error("accepted word did not start the sequence");

  a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_mouse_r) |-> (o_mx_r == '0 && o_my_r == '0 &&
                                     o_button_r == seq_pkg::EV_CONT))
    else $error("mouse fields not cleared without a move");

  a_transition_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_stroke_r != seq_pkg::EV_CONT) |-> o_mouse_r)
    else $error("pen transition without a mouse move");

  a_click_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && click_r) |-> !o_point_r)
    else $error("draw point emitted in click mode");

endmodule

`default_nettype wire
